@@ design/bmbs_pkg.sv @@
// Shared types and constants for the balanced multi-bank stack.
// Depends on nothing; imported by every module of the block.
`timescale 1ns / 1ps
`default_nettype none

package bmbs_pkg;

  localparam int MaxBanksDefault  = 8;
  localparam int BankDepthDefault = 1024;

  localparam int WordW   = 32;
  localparam int StatusW = 2;
  localparam int BankOutW = 3;
  localparam int BanksInUseW = 4;

  // result status codes
  localparam logic [StatusW-1:0] StDone  = 2'd0;
  localparam logic [StatusW-1:0] StFull  = 2'd1;
  localparam logic [StatusW-1:0] StEmpty = 2'd2;
  localparam logic [StatusW-1:0] StLimit = 2'd3;

  // configuration register indexes
  localparam logic RegBanksInUse = 1'b0;
  localparam logic RegItemLimit  = 1'b1;

  // request codes
  localparam logic ModePush = 1'b0;
  localparam logic ModePop  = 1'b1;

  typedef enum logic [3:0] {
    StateIdle   = 4'b0001,
    StateScan   = 4'b0010,
    StateDecide = 4'b0100,
    StatePopOut = 4'b1000
  } state_e;

  // control from the sequencer to the bank selector
  typedef struct packed {
    logic load;    // take the current bank as the first candidate
    logic step;    // compare the current bank against the best so far
    logic is_pop;  // pop keeps the fullest bank, push the emptiest
  } sel_ctrl_t;

endpackage

`default_nettype wire

@@ design/bmbs_select.sv @@
// Bank selector: one shared comparator that walks the bank fill counts,
// one bank per cycle, and keeps the best bank. Depends on bmbs_pkg.
`timescale 1ns / 1ps
`default_nettype none

module bmbs_select
  import bmbs_pkg::*;
#(
  parameter int MAX_BANKS  = MaxBanksDefault,
  parameter int BANK_DEPTH = BankDepthDefault,
  localparam int BankW = (MAX_BANKS > 1) ? $clog2(MAX_BANKS) : 1,
  localparam int CntW  = $clog2(BANK_DEPTH + 1)
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire sel_ctrl_t        ctrl_i,
  input  wire logic [BankW-1:0] idx_i,
  input  wire logic [CntW-1:0]  cnt_i,
  output logic      [BankW-1:0] best_idx_o,
  output logic      [CntW-1:0]  best_cnt_o
);

  logic [BankW-1:0] best_idx_q, best_idx_d;
  logic [CntW-1:0]  best_cnt_q, best_cnt_d;
  logic             better;

  // strict compare: ties keep the lower index already held
  assign better = ctrl_i.is_pop ? (cnt_i > best_cnt_q) : (cnt_i < best_cnt_q);

  always_comb begin
    best_idx_d = best_idx_q;
    best_cnt_d = best_cnt_q;
    if (ctrl_i.load) begin
      best_idx_d = idx_i;
      best_cnt_d = cnt_i;
    end else if (ctrl_i.step && better) begin
      best_idx_d = idx_i;
      best_cnt_d = cnt_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      best_idx_q <= '0;
      best_cnt_q <= '0;
    end else begin
      best_idx_q <= best_idx_d;
      best_cnt_q <= best_cnt_d;
    end
  end

  assign best_idx_o = best_idx_q;
  assign best_cnt_o = best_cnt_q;

endmodule

`default_nettype wire

@@ design/balanced_multi_bank_stack.sv @@
// Top level of the balanced multi-bank stack: sequencer, fill counts, word
// memory and result registers. Depends on bmbs_pkg and bmbs_select.
`timescale 1ns / 1ps
`default_nettype none

// Usage
//   Request channel: drive mode_i and push_word_i with start high; the request
//   is taken at a clock edge where start is high and busy is low. mode_i 0
//   pushes push_word_i, 1 pops a word.
//   Result channel: done_o is high for exactly one cycle with status_o,
//   bank_chosen_o and pop_word_o. The receiver cannot stall; every request
//   gives one result, in request order.
//   Configuration: cfg_we_i with cfg_idx_i (0 banks_in_use, 1 item_limit)
//   and cfg_wdata_i writes a register at once. Write only while idle.
// Sequence (N = active bank count, 1..MAX_BANKS)
//   A push past the item limit is refused from idle, with no scan.
//   Push: scan of N fill counts, then decide (write unless the bank is full).
//   Pop:  scan of N fill counts, decide, then pop-out if a word was read.
//   The scan uses one shared comparator, one fill count per cycle; decide
//   does at most one memory write (push) or registered read (pop).
// Reset: fill counts and push total clear, banks_in_use goes to 8,
//   item_limit to all ones. Word memory is not cleared and needs no sweep;
//   a pop only reads words written by an earlier push.
module balanced_multi_bank_stack
  import bmbs_pkg::*;
#(
  parameter int MAX_BANKS  = MaxBanksDefault,
  parameter int BANK_DEPTH = BankDepthDefault
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                start,
  output logic                     busy,
  input  wire logic                mode_i,
  input  wire logic [WordW-1:0]    push_word_i,
  output logic                     done_o,
  output logic      [StatusW-1:0]  status_o,
  output logic      [BankOutW-1:0] bank_chosen_o,
  output logic      [WordW-1:0]    pop_word_o,
  input  wire logic                cfg_we_i,
  input  wire logic                cfg_idx_i,
  input  wire logic [WordW-1:0]    cfg_wdata_i
);

  localparam int BankW    = (MAX_BANKS > 1) ? $clog2(MAX_BANKS) : 1;
  localparam int CntW     = $clog2(BANK_DEPTH + 1);
  localparam int MemDepth = MAX_BANKS * BANK_DEPTH;
  localparam int AddrW    = $clog2(MemDepth);

  // configuration registers
  logic [BanksInUseW-1:0] banks_in_use_q;
  logic [WordW-1:0]       item_limit_q;

  // block state
  logic [CntW-1:0]  count_q [MAX_BANKS];
  logic [WordW-1:0] pushed_total_q;

  // sequencer
  state_e           state_q, state_d;
  logic             mode_q;
  logic [WordW-1:0] word_q;
  logic [BankW-1:0] scan_idx_q, scan_idx_d;
  logic [BankW-1:0] last_idx_q;

  // selector link
  sel_ctrl_t        sel_ctrl;
  logic [BankW-1:0] best_idx;
  logic [CntW-1:0]  best_cnt;

  // memory
  logic [WordW-1:0] mem_q [MemDepth];
  logic [WordW-1:0] rdata_q;
  logic [CntW-1:0]  slot;
  logic [AddrW-1:0] addr;
  logic             mem_we, mem_re;

  // results
  logic                done_q, done_d;
  logic [StatusW-1:0]  status_q, status_d;
  logic [BankOutW-1:0] bank_q, bank_d;
  logic [WordW-1:0]    pop_word_q, pop_word_d;

  logic       accept;
  logic [7:0] bu_ext, act_banks;
  logic       limit_hit;

  assign accept    = start && !busy;
  assign busy      = (state_q != StateIdle);
  assign limit_hit = (pushed_total_q >= item_limit_q);

  // clamp the active bank count to 1..MAX_BANKS
  assign bu_ext = 8'(banks_in_use_q);
  always_comb begin
    if (bu_ext == 8'd0) begin
      act_banks = 8'd1;
    end else if (bu_ext > 8'(MAX_BANKS)) begin
      act_banks = 8'(MAX_BANKS);
    end else begin
      act_banks = bu_ext;
    end
  end

  // configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      banks_in_use_q <= BanksInUseW'(8);
      item_limit_q   <= '1;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        RegBanksInUse: banks_in_use_q <= cfg_wdata_i[BanksInUseW-1:0];
        RegItemLimit:  item_limit_q   <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // selector walks the fill counts while scanning
  assign sel_ctrl.load   = (state_q == StateScan) && (scan_idx_q == '0);
  assign sel_ctrl.step   = (state_q == StateScan);
  assign sel_ctrl.is_pop = (mode_q == ModePop);

  bmbs_select #(
    .MAX_BANKS (MAX_BANKS),
    .BANK_DEPTH(BANK_DEPTH)
  ) u_select (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .ctrl_i    (sel_ctrl),
    .idx_i     (scan_idx_q),
    .cnt_i     (count_q[scan_idx_q]),
    .best_idx_o(best_idx),
    .best_cnt_o(best_cnt)
  );

  // memory address: push writes above the top, pop reads the top
  assign slot = (mode_q == ModePop) ? (best_cnt - CntW'(1)) : best_cnt;
  assign addr = AddrW'(AddrW'(best_idx) * AddrW'(BANK_DEPTH)) + AddrW'(slot);

  always_comb begin
    state_d    = state_q;
    scan_idx_d = scan_idx_q;
    done_d     = 1'b0;
    status_d   = status_q;
    bank_d     = bank_q;
    pop_word_d = pop_word_q;
    mem_we     = 1'b0;
    mem_re     = 1'b0;
    unique case (state_q)
      StateIdle: begin
        if (accept) begin
          if ((mode_i == ModePush) && limit_hit) begin
            // refuse at once, no scan needed
            done_d     = 1'b1;
            status_d   = StLimit;
            bank_d     = '0;
            pop_word_d = '0;
          end else begin
            scan_idx_d = '0;
            state_d    = StateScan;
          end
        end
      end
      StateScan: begin
        scan_idx_d = scan_idx_q + BankW'(1);
        if (scan_idx_q == last_idx_q) begin
          state_d = StateDecide;
        end
      end
      StateDecide: begin
        if (mode_q == ModePush) begin
          done_d     = 1'b1;
          pop_word_d = '0;
          state_d    = StateIdle;
          if (best_cnt == CntW'(BANK_DEPTH)) begin
            status_d = StFull;
            bank_d   = '0;
          end else begin
            mem_we   = 1'b1;
            status_d = StDone;
            bank_d   = BankOutW'(best_idx);
          end
        end else if (best_cnt == '0) begin
          done_d     = 1'b1;
          status_d   = StEmpty;
          bank_d     = '0;
          pop_word_d = '0;
          state_d    = StateIdle;
        end else begin
          // read the top word into rdata_q; the pop-out state delivers it
          mem_re  = 1'b1;
          state_d = StatePopOut;
        end
      end
      StatePopOut: begin
        done_d     = 1'b1;
        status_d   = StDone;
        bank_d     = BankOutW'(best_idx);
        pop_word_d = rdata_q;
        state_d    = StateIdle;
      end
      default: state_d = StateIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= StateIdle;
      scan_idx_q <= '0;
      last_idx_q <= '0;
      mode_q     <= ModePush;
      done_q     <= 1'b0;
    end else begin
      state_q    <= state_d;
      scan_idx_q <= scan_idx_d;
      done_q     <= done_d;
      if (accept) begin
        mode_q     <= mode_i;
        last_idx_q <= BankW'(act_banks - 8'd1);
      end
    end
  end

  // payload registers hold without reset
  always_ff @(posedge clk_i) begin
    if (accept) begin
      word_q <= push_word_i;
    end
    status_q   <= status_d;
    bank_q     <= bank_d;
    pop_word_q <= pop_word_d;
  end

  // fill counts change on a successful push or pop; push total counts pushes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < MAX_BANKS; i++) begin
        count_q[i] <= '0;
      end
      pushed_total_q <= '0;
    end else if (mem_we) begin
      count_q[best_idx] <= best_cnt + CntW'(1);
      pushed_total_q    <= pushed_total_q + WordW'(1);
    end else if (mem_re) begin
      count_q[best_idx] <= best_cnt - CntW'(1);
    end
  end

  // word memory: one write or one registered read per cycle
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[addr] <= word_q;
    end
    if (mem_re) begin
      rdata_q <= mem_q[addr];
    end
  end

  assign done_o        = done_q;
  assign status_o      = status_q;
  assign bank_chosen_o = bank_q;
  assign pop_word_o    = pop_word_q;

endmodule

`default_nettype wire
